@@ src/lsr_pkg.sv @@
// types and constants shared by the slot replacer
package lsr_pkg;

  localparam int CAP_W = 8;
  localparam int SCAN_W = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;
  localparam logic [SCAN_W-1:0] SCAN_RESET = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN = 4'd1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TOUCH = 1'b1;

  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_FRESH    = 3'd1,
    ST_EVICTED  = 3'd2,
    ST_TOUCHED  = 3'd3,
    ST_REJECTED = 3'd4
  } lsr_status_e;

  typedef struct packed {
    logic        kind;
    logic        class_fits;
    logic [2:0]  class_id;
    logic [6:0]  slot_index;
    logic [31:0] expiry_time;
    logic [31:0] current_time;
  } lsr_req_t;

  typedef struct packed {
    logic [6:0] chosen_slot;
    logic [2:0] status;
  } lsr_rsp_t;

endpackage

@@ src/lsr_if.sv @@
// valid/ready channel interfaces for requests, results and configuration
interface lsr_req_if;
  import lsr_pkg::*;
  logic     valid;
  logic     ready;
  lsr_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsr_rsp_if;
  import lsr_pkg::*;
  logic     valid;
  logic     ready;
  lsr_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsr_cfg_if;
  import lsr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ src/lsr_ram.sv @@
// simple dual port memory, one write and one registered read per cycle
module lsr_ram #(
  parameter int DW = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DW-1:0]            rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/lsr_ctrl.sv @@
// sequencer that scans, allocates and relinks slots over the order and expiry memories
module lsr_ctrl import lsr_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int MAX_SLOTS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CAP_W-1:0]  cap_i,
  input  logic [SCAN_W-1:0] scan_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  lsr_req_t          req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output lsr_rsp_t          rsp_o
);

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int NW = $clog2(MAX_SLOTS + 1);
  localparam int DEPTH = NUM_CLASSES * MAX_SLOTS;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int XW = (NW > CAP_W) ? NW : CAP_W;

  typedef enum logic [13:0] {
    S_IDLE   = 14'd1,
    S_DECIDE = 14'd2,
    S_T_RD   = 14'd4,
    S_T_CHK  = 14'd8,
    S_X_RD   = 14'd16,
    S_X_ERD  = 14'd32,
    S_X_CHK  = 14'd64,
    S_PICK   = 14'd128,
    S_E_RD   = 14'd256,
    S_E_CHK  = 14'd512,
    S_SH_RD  = 14'd1024,
    S_SH_WR  = 14'd2048,
    S_FRONT  = 14'd4096,
    S_RESP   = 14'd8192
  } state_e;

  state_e             state_q, state_d;
  lsr_req_t           req_q;
  logic [NW-1:0]      cnt_q [NUM_CLASSES];
  logic [NW-1:0]      count_q;
  logic [NW-1:0]      pos_q;
  logic [SCAN_W-1:0]  depth_q;
  logic [SCAN_W-1:0]  iter_q;
  logic [SW-1:0]      slot_q;
  lsr_status_e        status_q;
  logic               rsp_valid_q;
  lsr_rsp_t           rsp_q;

  logic [CW-1:0]      cls_idx;
  logic               cls_ok;
  logic [NW-1:0]      cnt_cur;
  logic [AW-1:0]      base;
  logic [XW-1:0]      limit;
  logic [NW-1:0]      ord_ridx;
  logic [AW-1:0]      ord_raddr;
  logic [SW-1:0]      ord_rdata;
  logic               ord_we;
  logic [AW-1:0]      ord_waddr;
  logic [SW-1:0]      ord_wdata;
  logic [AW-1:0]      exp_raddr;
  logic [31:0]        exp_rdata;
  logic               exp_we;
  logic [AW-1:0]      exp_waddr;
  logic [NW-1:0]      scan_pos;

  assign cls_idx = CW'(req_q.class_id);
  assign cls_ok = int'(req_q.class_id) < NUM_CLASSES;
  assign cnt_cur = cnt_q[cls_idx];
  assign base = AW'(cls_idx) * AW'(MAX_SLOTS);
  assign scan_pos = count_q - NW'(1) - NW'(iter_q);

  always_comb begin
    if (cap_i == '0) begin
      limit = XW'(1);
    end else if (XW'(cap_i) > XW'(MAX_SLOTS)) begin
      limit = XW'(MAX_SLOTS);
    end else begin
      limit = XW'(cap_i);
    end
  end

  always_comb begin
    case (state_q)
      S_X_RD:  ord_ridx = scan_pos;
      S_E_RD:  ord_ridx = count_q - NW'(1);
      S_SH_RD: ord_ridx = pos_q - NW'(1);
      default: ord_ridx = pos_q;
    endcase
  end

  assign ord_raddr = base + AW'(ord_ridx);
  assign exp_raddr = base + AW'(ord_rdata);

  // order memory writes: shift step and final front write
  assign ord_we = (state_q == S_SH_WR) || (state_q == S_FRONT);
  assign ord_waddr = (state_q == S_SH_WR) ? base + AW'(pos_q) : base;
  assign ord_wdata = (state_q == S_SH_WR) ? ord_rdata : slot_q;

  always_comb begin
    exp_we = 1'b0;
    exp_waddr = base + AW'(ord_rdata);
    case (state_q)
      S_X_CHK: begin
        exp_we = (req_q.current_time >= exp_rdata);
        exp_waddr = base + AW'(slot_q);
      end
      S_PICK: begin
        exp_we = (XW'(count_q) < limit);
        exp_waddr = base + AW'(count_q);
      end
      S_E_CHK: begin
        exp_we = 1'b1;
      end
      default: exp_we = 1'b0;
    endcase
  end

  lsr_ram #(.DW(SW), .DEPTH(DEPTH)) u_order (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  lsr_ram #(.DW(32), .DEPTH(DEPTH)) u_expiry (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (req_q.expiry_time),
    .raddr_i (exp_raddr),
    .rdata_o (exp_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!cls_ok) begin
          state_d = S_RESP;
        end else if (req_q.kind == KIND_TOUCH) begin
          state_d = (XW'(req_q.slot_index) >= XW'(cnt_cur)) ? S_RESP : S_T_RD;
        end else if (!req_q.class_fits) begin
          state_d = S_RESP;
        end else if (scan_i == '0 || cnt_cur == '0) begin
          state_d = S_PICK;
        end else begin
          state_d = S_X_RD;
        end
      end
      S_T_RD:   state_d = S_T_CHK;
      S_T_CHK: begin
        if (ord_rdata == SW'(req_q.slot_index)) begin
          state_d = S_SH_RD;
        end else if (pos_q + NW'(1) == count_q) begin
          state_d = S_RESP;
        end else begin
          state_d = S_T_RD;
        end
      end
      S_X_RD:   state_d = S_X_ERD;
      S_X_ERD:  state_d = S_X_CHK;
      S_X_CHK: begin
        if (req_q.current_time >= exp_rdata) begin
          state_d = S_SH_RD;
        end else if (iter_q + SCAN_W'(1) == depth_q) begin
          state_d = S_PICK;
        end else begin
          state_d = S_X_RD;
        end
      end
      S_PICK:   state_d = (XW'(count_q) < limit) ? S_SH_RD : S_E_RD;
      S_E_RD:   state_d = S_E_CHK;
      S_E_CHK:  state_d = S_SH_RD;
      S_SH_RD:  state_d = (pos_q == '0) ? S_FRONT : S_SH_WR;
      S_SH_WR:  state_d = S_SH_RD;
      S_FRONT:  state_d = S_RESP;
      S_RESP:   if (!rsp_valid_q || rsp_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rsp_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cnt_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_RESP && (!rsp_valid_q || rsp_ready_i)) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (state_q == S_PICK && XW'(count_q) < limit) begin
        cnt_q[cls_idx] <= count_q + NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q <= req_i;
        status_q <= ST_REJECTED;
        slot_q <= '0;
      end
      S_DECIDE: begin
        count_q <= cnt_cur;
        pos_q <= '0;
        iter_q <= '0;
        if (XW'(scan_i) > XW'(cnt_cur)) begin
          depth_q <= SCAN_W'(cnt_cur);
        end else begin
          depth_q <= scan_i;
        end
      end
      S_T_CHK: begin
        if (ord_rdata == SW'(req_q.slot_index)) begin
          slot_q <= ord_rdata;
          status_q <= ST_TOUCHED;
        end else begin
          pos_q <= pos_q + NW'(1);
        end
      end
      S_X_RD:  pos_q <= scan_pos;
      S_X_ERD: slot_q <= ord_rdata;
      S_X_CHK: begin
        if (req_q.current_time >= exp_rdata) begin
          status_q <= ST_REUSED;
        end else begin
          iter_q <= iter_q + SCAN_W'(1);
        end
      end
      S_PICK: begin
        if (XW'(count_q) < limit) begin
          slot_q <= SW'(count_q);
          pos_q <= count_q;
          status_q <= ST_FRESH;
        end else begin
          pos_q <= count_q - NW'(1);
        end
      end
      S_E_CHK: begin
        slot_q <= ord_rdata;
        status_q <= ST_EVICTED;
      end
      S_SH_WR: pos_q <= pos_q - NW'(1);
      S_RESP: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          rsp_q.chosen_slot <= (status_q == ST_REJECTED) ? 7'd0 : 7'(slot_q);
          rsp_q.status <= status_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o = rsp_q;

endmodule

@@ src/lru_slot_replacer_with_expiry.sv @@
// top level: configuration registers and channel hookup of the slot replacer
// One request is handled at a time. A rejected request goes from the decision
// state straight to the result state. A touch searches the class order one
// position at a time and then moves the slot to the front one position at a
// time. An insert checks each scanned least recent slot in turn, then relinks
// the chosen slot to the front one position at a time. The order memory has
// one registered read and one write per cycle. The result sits in an output
// register; a new request is taken as soon as the previous result has been
// loaded there. No clearing pass is needed after reset.
module lru_slot_replacer_with_expiry import lsr_pkg::*; #(
  parameter int NUM_CLASSES = 8,
  parameter int MAX_SLOTS = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lsr_cfg_if.sink  cfg_i,
  lsr_req_if.sink  req_i,
  lsr_rsp_if.source rsp_o
);

  logic [CAP_W-1:0]  cap_q;
  logic [SCAN_W-1:0] scan_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      scan_q <= SCAN_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CAPACITY: cap_q <= cfg_i.wdata[CAP_W-1:0];
        CFG_SCAN:     scan_q <= cfg_i.wdata[SCAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lsr_ctrl #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .scan_i      (scan_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.data)
  );

endmodule

@@ tb/tb_lsr_if.sv @@
// probe that counts words accepted on the request and result channels
`timescale 1ns / 1ps
interface tb_lsr_mon_if (input logic clk_i);
  logic        req_fire;
  logic        rsp_fire;
  int unsigned req_words = 0;
  int unsigned rsp_words = 0;

  always @(posedge clk_i) begin
    if (req_fire) req_words <= req_words + 1;
    if (rsp_fire) rsp_words <= rsp_words + 1;
  end
endinterface

@@ tb/tb_top.sv @@
// testbench for the lru slot replacer with expiry: directed and random requests
`timescale 1ns / 1ps
module tb_top import lsr_pkg::*; ();

  localparam int NCLS = 8;
  localparam int NSLOT = 128;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  lsr_cfg_if cfg_ch();
  lsr_req_if req_ch();
  lsr_rsp_if rsp_ch();
  tb_lsr_mon_if mon (.clk_i(clk_i));

  assign mon.req_fire = req_ch.valid & req_ch.ready;
  assign mon.rsp_fire = rsp_ch.valid & rsp_ch.ready;

  lru_slot_replacer_with_expiry i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch.sink),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  // predictor state
  logic [6:0]  order_q [NCLS][NSLOT];
  logic [31:0] expiry_q [NCLS][NSLOT];
  int unsigned count_q [NCLS];
  int unsigned cap_q;
  int unsigned scan_q;
  lsr_rsp_t    pending_rsp[$];
  int          mismatches;
  int          rsp_seen;
  int          words_sent;
  logic [31:0] now_q;

  task automatic move_front(input int c, input int p);
    logic [6:0] s;
    s = order_q[c][p];
    for (int k = p; k > 0; k--) order_q[c][k] = order_q[c][k-1];
    order_q[c][0] = s;
  endtask

  task automatic predict_slot(input lsr_req_t r, output lsr_rsp_t o);
    int c, n, lim, dep, p;
    logic [6:0] s;
    c = r.class_id;
    n = count_q[c];
    o.chosen_slot = '0;
    o.status = ST_REJECTED;
    if (r.kind == KIND_TOUCH) begin
      if (r.slot_index < n) begin
        for (p = 0; p < n; p++) begin
          if (order_q[c][p] == r.slot_index) begin
            move_front(c, p);
            o.chosen_slot = r.slot_index;
            o.status = ST_TOUCHED;
            return;
          end
        end
      end
      return;
    end
    if (!r.class_fits) return;
    lim = (cap_q == 0) ? 1 : (cap_q > NSLOT ? NSLOT : cap_q);
    dep = (scan_q > n) ? n : scan_q;
    for (int i = 0; i < dep; i++) begin
      p = n - 1 - i;
      s = order_q[c][p];
      if (r.current_time >= expiry_q[c][s]) begin
        expiry_q[c][s] = r.expiry_time;
        move_front(c, p);
        o.chosen_slot = s;
        o.status = ST_REUSED;
        return;
      end
    end
    if (n < lim) begin
      order_q[c][n] = n[6:0];
      expiry_q[c][n] = r.expiry_time;
      count_q[c] = n + 1;
      move_front(c, n);
      o.chosen_slot = n[6:0];
      o.status = ST_FRESH;
      return;
    end
    s = order_q[c][n-1];
    expiry_q[c][s] = r.expiry_time;
    move_front(c, n - 1);
    o.chosen_slot = s;
    o.status = ST_EVICTED;
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
  end

  // result side: random stall per word, then compare
  initial begin
    lsr_rsp_t want;
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
      rsp_seen++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word slot=%0d status=%0d",
          rsp_ch.data.chosen_slot, rsp_ch.data.status);
      end else begin
        want = pending_rsp.pop_front();
        if (want.chosen_slot !== rsp_ch.data.chosen_slot ||
            want.status !== rsp_ch.data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected slot=%0d status=%0d got slot=%0d status=%0d",
              want.chosen_slot, want.status, rsp_ch.data.chosen_slot,
              rsp_ch.data.status);
        end
      end
    end
  end

  task automatic send_req(input lsr_req_t r, input bit no_gap = 0);
    lsr_rsp_t o;
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_slot(r, o);
    pending_rsp.push_back(o);
    words_sent++;
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v[7:0];
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    if (idx == CFG_CAPACITY) cap_q = v & 8'hff;
    else if (idx == CFG_SCAN) scan_q = v & 4'hf;
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic lsr_req_t make_insert(input int c, input logic [31:0] exp_t,
                                           input logic [31:0] t);
    lsr_req_t r;
    r = '0;
    r.kind = KIND_INSERT;
    r.class_fits = 1'b1;
    r.class_id = c[2:0];
    r.slot_index = 7'($urandom_range(0, 127));
    r.expiry_time = exp_t;
    r.current_time = t;
    return r;
  endfunction

  function automatic lsr_req_t make_touch(input int c, input int s, input logic [31:0] t);
    lsr_req_t r;
    r = '0;
    r.kind = KIND_TOUCH;
    r.class_fits = 1'($urandom_range(0, 1));
    r.class_id = c[2:0];
    r.slot_index = s[6:0];
    r.expiry_time = $urandom();
    r.current_time = t;
    return r;
  endfunction

  task automatic test_directed();
    lsr_req_t r;
    r = make_insert(0, 32'd10, 32'd0);
    r.class_fits = 1'b0;
    send_req(r);
    send_req(make_touch(1, 0, 0));
    send_req(make_insert(0, 32'hffff_ffff, 32'd0));
    send_req(make_insert(0, 32'd5, 32'd0));
    send_req(make_insert(0, 32'd0, 32'd0));
    send_req(make_touch(0, 127, 32'd1));
    send_req(make_touch(0, 2, 32'd1));
    send_req(make_touch(0, 0, 32'd1));
    send_req(make_insert(0, 32'd100, 32'd6));
    send_req(make_insert(0, 32'd100, 32'hffff_ffff));
    send_req(make_insert(7, 32'd1, 32'd0));
    send_req(make_touch(7, 0, 32'd0));
    r = make_touch(7, 1, 32'd0);
    r.class_fits = 1'b0;
    send_req(r);
    drain_results();
    write_reg(CFG_CAPACITY, 0);
    write_reg(CFG_SCAN, 0);
    send_req(make_insert(3, 32'd1, 32'd0));
    send_req(make_insert(3, 32'd1, 32'd9));
    send_req(make_insert(2, 32'd1, 32'd9));
    drain_results();
    write_reg(CFG_CAPACITY, 255);
    write_reg(CFG_SCAN, 15);
    send_req(make_insert(3, 32'd1, 32'd9));
    send_req(make_insert(3, 32'd50, 32'd9));
    drain_results();
  endtask

  task automatic test_random(input int n, input int cap, input int scan);
    int c, kindsel;
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_SCAN, scan);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom_range(4, 6);
      now_q = now_q + $urandom_range(0, 6);
      kindsel = $urandom_range(0, 9);
      if (kindsel < 6)
        send_req(make_insert(c, now_q + $urandom_range(0, 40), now_q));
      else if (kindsel < 9)
        send_req(make_touch(c, $urandom_range(0, count_q[c] + 1), now_q));
      else begin
        lsr_req_t r;
        r.kind = 1'($urandom_range(0, 1));
        r.class_fits = 1'($urandom_range(0, 1));
        r.class_id = 3'($urandom_range(0, 7));
        r.slot_index = 7'($urandom_range(0, 127));
        r.expiry_time = $urandom();
        r.current_time = $urandom();
        send_req(r, 1'($urandom_range(0, 1)));
      end
      if (i == n / 2) drain_results();
    end
    drain_results();
  endtask

  task automatic test_capacity_shrink();
    write_reg(CFG_CAPACITY, 2);
    write_reg(CFG_SCAN, 8);
    for (int i = 0; i < 60; i++) begin
      now_q = now_q + $urandom_range(0, 3);
      send_req(make_insert(5, now_q + $urandom_range(0, 10), now_q));
    end
    drain_results();
  endtask

  initial begin
    for (int c = 0; c < NCLS; c++) begin
      count_q[c] = 0;
      for (int s = 0; s < NSLOT; s++) begin
        order_q[c][s] = '0;
        expiry_q[c][s] = '0;
      end
    end
    cap_q = CAP_RESET;
    scan_q = SCAN_RESET;
    now_q = 32'd100;
    mismatches = 0;
    rsp_seen = 0;
    words_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(500, 128, 8);
    test_random(400, 20, 3);
    test_capacity_shrink();
    test_random(400, 1, 1);
    $display("covered %0d requests and %0d result words over several capacity and scan settings",
      words_sent, rsp_seen);
    $display("channel probe saw %0d request and %0d result handshakes",
      mon.req_words, mon.rsp_words);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
